// ===== rtl/core/csv_byte_tokenizer_core_macros.svh =====
// Assertion helpers used by the tokenizer core RTL.
`ifndef CSV_BYTE_TOKENIZER_CORE_MACROS_SVH
`define CSV_BYTE_TOKENIZER_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CSVT_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("csvt: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define CSVT_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("csvt: next-cycle check failed");

`endif

// ===== rtl/core/csvt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package csvt_pkg;

  localparam int CELL_MAX_DEF   = 64;
  localparam int COUNT_BITS_DEF = 32;
  // Cell positions fit the default maximum cell size.
  localparam int POS_W    = 7;
  localparam int NBANK    = 4;
  localparam int BANK_W   = 2;
  localparam int JQ_DEPTH = 2;

  localparam logic [7:0] QUOTE_CHAR = 8'h22;
  localparam logic [7:0] CR_CHAR    = 8'h0D;
  localparam logic [7:0] LF_CHAR    = 8'h0A;

  localparam logic [2:0] REG_SEPARATOR     = 3'd0;
  localparam logic [2:0] REG_TRIM          = 3'd1;
  localparam logic [2:0] REG_QUOTED_BREAKS = 3'd2;
  localparam logic [2:0] REG_UNQUOTE       = 3'd3;
  localparam logic [2:0] REG_SKIP_COMMENT  = 3'd4;
  localparam logic [2:0] REG_COMMENT_CHAR  = 3'd5;
  localparam logic [2:0] REG_SKIP_EMPTY    = 3'd6;

  typedef struct packed {
    logic [7:0] separator_char;
    logic       trim_enable;
    logic       quoted_breaks_enable;
    logic       unquote_enable;
    logic       skip_comment_rows;
    logic [7:0] comment_char;
    logic       skip_empty_rows;
  } cfg_t;

  typedef struct packed {
    logic [BANK_W-1:0] bank;
    logic [POS_W-1:0]  start;
    logic [POS_W-1:0]  stop;
    logic              unq;
    logic              ovf;
    logic              first;
    logic              ends_row;
    logic              is_end;
    logic              has_cell;
    logic              style;
  } job_t;

  typedef struct packed {
    logic [7:0] data;
    logic       byte_valid;
    logic       cell_end;
    logic       row_end;
    logic       overflow;
    logic       stream_end;
    logic       crlf;
    logic       last;
  } res_t;

  typedef enum logic [1:0] {
    BS_IDLE,
    BS_PROC,
    BS_FIN
  } back_state_t;

  function automatic logic is_blank(input logic [7:0] b);
    return (b == 8'd32) || ((b >= 8'd9) && (b <= 8'd13));
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/csvt_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
module csvt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/csvt_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module csvt_front #(
  parameter int CELL_MAX   = csvt_pkg::CELL_MAX_DEF,
  parameter int COUNT_BITS = csvt_pkg::COUNT_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire csvt_pkg::cfg_t         cfg,
  input  wire logic                   push,
  input  wire logic                   full,
  input  wire logic [7:0]             text_byte,
  input  wire logic                   end_of_text,
  output logic                        ram_we,
  output logic [csvt_pkg::BANK_W+$clog2(CELL_MAX)-1:0] ram_waddr,
  output logic [7:0]                  ram_wdata,
  output logic                        job_push,
  output csvt_pkg::job_t              job
);

  localparam int LEN_W  = $clog2(CELL_MAX + 1);
  localparam int ADDR_W = $clog2(CELL_MAX);

  logic [LEN_W-1:0] len_r, len_nxt, lo_r, lo_nxt, hi_r, hi_nxt;
  logic started_r, started_nxt, fq_r, fq_nxt, drop_r, drop_nxt;
  logic inq_r, inq_nxt, rhc_r, rhc_nxt, nb_r, nb_nxt;
  logic loq_r, loq_nxt, hiq_r, hiq_nxt, lastq_r, lastq_nxt;
  logic [COUNT_BITS-1:0] cr_r, cr_nxt, lf_r, lf_nxt;
  logic [csvt_pkg::BANK_W-1:0] bank_r, bank_nxt;

  logic acc, is_q, do_append, room;
  logic [LEN_W-1:0] lo, hi, c_start, c_stop;
  logic lq, hq, unq_ok;

  assign acc  = push && !full;
  assign is_q = (text_byte == csvt_pkg::QUOTE_CHAR);
  assign room = (len_r < LEN_W'(CELL_MAX));

  // Bounds of the cell as it would be emitted if it closed now.
  always_comb begin
    if (cfg.trim_enable) begin
      lo = nb_r ? lo_r : '0;
      hi = nb_r ? hi_r : '0;
      lq = nb_r && loq_r;
      hq = nb_r && hiq_r;
    end else begin
      lo = '0;
      hi = len_r;
      lq = fq_r && (len_r != '0);
      hq = lastq_r && (len_r != '0);
    end
    unq_ok  = cfg.unquote_enable && ((hi - lo) >= LEN_W'(2)) && lq && hq;
    c_start = unq_ok ? lo + LEN_W'(1) : lo;
    c_stop  = unq_ok ? hi - LEN_W'(1) : hi;
  end

  always_comb begin
    len_nxt = len_r; lo_nxt = lo_r; hi_nxt = hi_r;
    started_nxt = started_r; fq_nxt = fq_r; drop_nxt = drop_r;
    inq_nxt = inq_r; rhc_nxt = rhc_r; nb_nxt = nb_r;
    loq_nxt = loq_r; hiq_nxt = hiq_r; lastq_nxt = lastq_r;
    cr_nxt = cr_r; lf_nxt = lf_r; bank_nxt = bank_r;
    do_append = 1'b0;
    job_push  = 1'b0;
    job.bank     = bank_r;
    job.start    = csvt_pkg::POS_W'(c_start);
    job.stop     = csvt_pkg::POS_W'(c_stop);
    job.unq      = unq_ok;
    job.ovf      = drop_r;
    job.first    = !rhc_r;
    job.ends_row = 1'b0;
    job.is_end   = 1'b0;
    job.has_cell = 1'b1;
    job.style    = 1'b0;

    if (acc) begin
      if (end_of_text) begin
        job_push     = 1'b1;
        job.ends_row = 1'b1;
        job.is_end   = 1'b1;
        job.has_cell = started_r || rhc_r;
        job.style    = (cr_r > (lf_r >> 1));
        rhc_nxt = 1'b0; inq_nxt = 1'b0;
        cr_nxt = '0; lf_nxt = '0;
      end else if (is_q) begin
        if (!started_r || fq_r) begin
          inq_nxt = !inq_r;
        end
        do_append = 1'b1;
      end else if (text_byte == cfg.separator_char) begin
        if (!inq_r) begin
          job_push = 1'b1;
          rhc_nxt  = 1'b1;
        end else begin
          do_append = 1'b1;
        end
      end else if (text_byte == csvt_pkg::CR_CHAR) begin
        if (cfg.quoted_breaks_enable && inq_r) begin
          do_append = 1'b1;
        end else begin
          cr_nxt = cr_r + COUNT_BITS'(1);
        end
      end else if (text_byte == csvt_pkg::LF_CHAR) begin
        if (cfg.quoted_breaks_enable && inq_r) begin
          do_append = 1'b1;
        end else begin
          lf_nxt = lf_r + COUNT_BITS'(1);
          // Drop a bare empty line when asked; quoted state stays as it is.
          if (!(cfg.skip_empty_rows && !rhc_r && !started_r)) begin
            job_push     = 1'b1;
            job.ends_row = 1'b1;
            rhc_nxt = 1'b0; inq_nxt = 1'b0;
          end
        end
      end else begin
        do_append = 1'b1;
      end
    end

    if (job_push) begin
      bank_nxt = bank_r + csvt_pkg::BANK_W'(1);
      len_nxt = '0; started_nxt = 1'b0; fq_nxt = 1'b0; drop_nxt = 1'b0;
      nb_nxt = 1'b0; lastq_nxt = 1'b0;
    end

    if (do_append) begin
      started_nxt = 1'b1;
      if (!started_r) begin
        fq_nxt = is_q;
      end
      if (room) begin
        len_nxt   = len_r + LEN_W'(1);
        lastq_nxt = is_q;
        if (!csvt_pkg::is_blank(text_byte)) begin
          if (!nb_r) begin
            lo_nxt  = len_r;
            loq_nxt = is_q;
          end
          nb_nxt  = 1'b1;
          hi_nxt  = len_r + LEN_W'(1);
          hiq_nxt = is_q;
        end
      end else begin
        drop_nxt = 1'b1;
      end
    end
  end

  assign ram_we    = do_append && room;
  assign ram_waddr = {bank_r, len_r[ADDR_W-1:0]};
  assign ram_wdata = text_byte;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0; lo_r <= '0; hi_r <= '0;
      started_r <= 1'b0; fq_r <= 1'b0; drop_r <= 1'b0;
      inq_r <= 1'b0; rhc_r <= 1'b0; nb_r <= 1'b0;
      loq_r <= 1'b0; hiq_r <= 1'b0; lastq_r <= 1'b0;
      cr_r <= '0; lf_r <= '0; bank_r <= '0;
    end else begin
      len_r <= len_nxt; lo_r <= lo_nxt; hi_r <= hi_nxt;
      started_r <= started_nxt; fq_r <= fq_nxt; drop_r <= drop_nxt;
      inq_r <= inq_nxt; rhc_r <= rhc_nxt; nb_r <= nb_nxt;
      loq_r <= loq_nxt; hiq_r <= hiq_nxt; lastq_r <= lastq_nxt;
      cr_r <= cr_nxt; lf_r <= lf_nxt; bank_r <= bank_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/csvt_jobq.sv =====
`timescale 1ns / 1ps
`default_nettype none
module csvt_jobq #(
  parameter int DEPTH = csvt_pkg::JQ_DEPTH
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       push,
  input  wire csvt_pkg::job_t             din,
  input  wire logic                       pop,
  output logic                            valid,
  output csvt_pkg::job_t                  dout,
  output logic [$clog2(DEPTH+1)-1:0]      count
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  csvt_pkg::job_t slot_r [DEPTH];
  logic [PW-1:0] wp_r, rp_r;
  logic [CW-1:0] cnt_r;

  function automatic logic [PW-1:0] inc(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  assign valid = (cnt_r != '0);
  assign dout  = slot_r[rp_r];
  assign count = cnt_r;

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wp_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= inc(wp_r);
      end
      if (pop) begin
        rp_r <= inc(rp_r);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/csvt_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
module csvt_back #(
  parameter int CELL_MAX = csvt_pkg::CELL_MAX_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire csvt_pkg::cfg_t         cfg,
  input  wire logic                   q_valid,
  input  wire csvt_pkg::job_t         q_job,
  output logic                        q_pop,
  output logic                        rd_en,
  output logic [csvt_pkg::BANK_W+$clog2(CELL_MAX)-1:0] rd_addr,
  input  wire logic [7:0]             rd_data,
  output logic                        busy,
  input  wire logic                   pop,
  output logic                        out_valid,
  output csvt_pkg::res_t              out_res
);

  localparam int ADDR_W = $clog2(CELL_MAX);
  localparam int PW     = csvt_pkg::POS_W;

  csvt_pkg::back_state_t state_r, state_nxt;
  csvt_pkg::job_t job_r, job_nxt;
  logic [PW-1:0] idx_r, idx_nxt, idx_inc;
  logic [7:0] pend_r, pend_nxt;
  logic pend_v_r, pend_v_nxt, drop_r, drop_nxt, comment_r, comment_nxt;
  logic out_v_r;
  csvt_pkg::res_t out_r, res;
  logic slot_free, load, advance;

  assign slot_free = !out_v_r || pop;
  assign idx_inc   = idx_r + PW'(1);
  assign busy      = (state_r != csvt_pkg::BS_IDLE);

  always_comb begin
    state_nxt = state_r; job_nxt = job_r; idx_nxt = idx_r;
    pend_nxt = pend_r; pend_v_nxt = pend_v_r; drop_nxt = drop_r;
    comment_nxt = comment_r;
    q_pop = 1'b0; rd_en = 1'b0; load = 1'b0; advance = 1'b0;
    rd_addr = {job_r.bank, idx_r[ADDR_W-1:0]};
    res = '0;

    case (state_r)
      csvt_pkg::BS_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          job_nxt = q_job;
          idx_nxt = q_job.start;
          pend_v_nxt = 1'b0;
          drop_nxt = 1'b0;
          if (q_job.first) begin
            comment_nxt = 1'b0;
          end
          if (q_job.has_cell && !(comment_r && !q_job.first) &&
              (q_job.start != q_job.stop)) begin
            rd_en = 1'b1;
            rd_addr = {q_job.bank, q_job.start[ADDR_W-1:0]};
            state_nxt = csvt_pkg::BS_PROC;
          end else begin
            state_nxt = csvt_pkg::BS_FIN;
          end
        end
      end
      csvt_pkg::BS_PROC: begin
        if (job_r.first && (idx_r == job_r.start) && cfg.skip_comment_rows &&
            (rd_data == cfg.comment_char)) begin
          comment_nxt = 1'b1;
          state_nxt = csvt_pkg::BS_FIN;
        end else if (drop_r && (rd_data == csvt_pkg::QUOTE_CHAR)) begin
          // Second quote of an escaped pair.
          drop_nxt = 1'b0;
          advance = 1'b1;
        end else if (!pend_v_r || slot_free) begin
          if (pend_v_r) begin
            load = 1'b1;
            res.data = pend_r;
            res.byte_valid = 1'b1;
            res.overflow = job_r.ovf;
          end
          pend_nxt = rd_data;
          pend_v_nxt = 1'b1;
          drop_nxt = job_r.unq && (rd_data == csvt_pkg::QUOTE_CHAR);
          advance = 1'b1;
        end
        if (advance) begin
          idx_nxt = idx_inc;
          if (idx_inc == job_r.stop) begin
            state_nxt = csvt_pkg::BS_FIN;
          end else begin
            rd_en = 1'b1;
            rd_addr = {job_r.bank, idx_inc[ADDR_W-1:0]};
          end
        end
      end
      csvt_pkg::BS_FIN: begin
        if (!job_r.has_cell || comment_r) begin
          res.stream_end = 1'b1;
          res.crlf = job_r.style;
          res.last = 1'b1;
          if (!job_r.is_end || slot_free) begin
            load = job_r.is_end;
            state_nxt = csvt_pkg::BS_IDLE;
          end
        end else begin
          res.data = pend_v_r ? pend_r : 8'd0;
          res.byte_valid = pend_v_r;
          res.cell_end = 1'b1;
          res.row_end = job_r.ends_row;
          res.overflow = job_r.ovf;
          res.stream_end = job_r.is_end;
          res.crlf = job_r.is_end && job_r.style;
          res.last = 1'b1;
          if (slot_free) begin
            load = 1'b1;
            state_nxt = csvt_pkg::BS_IDLE;
          end
        end
        if ((state_nxt == csvt_pkg::BS_IDLE) && job_r.ends_row) begin
          comment_nxt = 1'b0;
        end
      end
      default: begin
        state_nxt = csvt_pkg::BS_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    job_r <= job_nxt;
    idx_r <= idx_nxt;
    pend_r <= pend_nxt;
    if (load) begin
      out_r <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= csvt_pkg::BS_IDLE;
      pend_v_r <= 1'b0; drop_r <= 1'b0; comment_r <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pend_v_r <= pend_v_nxt; drop_r <= drop_nxt; comment_r <= comment_nxt;
      if (load) begin
        out_v_r <= 1'b1;
      end else if (pop) begin
        out_v_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_v_r;
  assign out_res   = out_r;

endmodule
`default_nettype wire

// ===== rtl/core/csv_byte_tokenizer_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "csv_byte_tokenizer_core_macros.svh"
// CSV tokenizer: push one text byte (or an end mark) per transaction, pop cell bytes
// with cell, row and stream markers. The front end takes one byte per cycle while full is
// low and writes the open cell into one of four banks of a byte RAM; each closed cell
// becomes a job in a two-entry queue. The back end reads a cell from the RAM one byte per
// cycle while its output slot is free or being popped, and emits it. full rises while
// three cells are queued or draining; no clearing pass follows reset.
module csv_byte_tokenizer_core #(
  parameter int CELL_MAX   = csvt_pkg::CELL_MAX_DEF,
  parameter int COUNT_BITS = csvt_pkg::COUNT_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  in_text_byte,
  input  wire logic        in_end_of_text,
  output logic             empty,
  input  wire logic        pop,
  output logic [7:0]       out_byte,
  output logic             out_byte_valid,
  output logic             out_cell_end,
  output logic             out_row_end,
  output logic             out_cell_overflow,
  output logic             out_stream_end,
  output logic             out_crlf_style,
  output logic             out_last,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int AW = csvt_pkg::BANK_W + $clog2(CELL_MAX);
  localparam int CW = $clog2(csvt_pkg::JQ_DEPTH + 1);

  csvt_pkg::cfg_t cfg_r;
  logic cfg_we;
  logic [2:0] reg_idx;

  logic ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [7:0] ram_wdata, ram_rdata;
  logic job_push, q_pop, q_valid, back_busy, out_valid;
  csvt_pkg::job_t job_in, job_out;
  logic [CW-1:0] q_count;
  csvt_pkg::res_t res;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.separator_char       <= 8'd44;
      cfg_r.trim_enable          <= 1'b0;
      cfg_r.quoted_breaks_enable <= 1'b0;
      cfg_r.unquote_enable       <= 1'b1;
      cfg_r.skip_comment_rows    <= 1'b0;
      cfg_r.comment_char         <= 8'd35;
      cfg_r.skip_empty_rows      <= 1'b0;
    end else if (cfg_we) begin
      case (reg_idx)
        csvt_pkg::REG_SEPARATOR:     cfg_r.separator_char       <= pwdata[7:0];
        csvt_pkg::REG_TRIM:          cfg_r.trim_enable          <= pwdata[0];
        csvt_pkg::REG_QUOTED_BREAKS: cfg_r.quoted_breaks_enable <= pwdata[0];
        csvt_pkg::REG_UNQUOTE:       cfg_r.unquote_enable       <= pwdata[0];
        csvt_pkg::REG_SKIP_COMMENT:  cfg_r.skip_comment_rows    <= pwdata[0];
        csvt_pkg::REG_COMMENT_CHAR:  cfg_r.comment_char         <= pwdata[7:0];
        csvt_pkg::REG_SKIP_EMPTY:    cfg_r.skip_empty_rows      <= pwdata[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      csvt_pkg::REG_SEPARATOR:     prdata = {24'd0, cfg_r.separator_char};
      csvt_pkg::REG_TRIM:          prdata = {31'd0, cfg_r.trim_enable};
      csvt_pkg::REG_QUOTED_BREAKS: prdata = {31'd0, cfg_r.quoted_breaks_enable};
      csvt_pkg::REG_UNQUOTE:       prdata = {31'd0, cfg_r.unquote_enable};
      csvt_pkg::REG_SKIP_COMMENT:  prdata = {31'd0, cfg_r.skip_comment_rows};
      csvt_pkg::REG_COMMENT_CHAR:  prdata = {24'd0, cfg_r.comment_char};
      csvt_pkg::REG_SKIP_EMPTY:    prdata = {31'd0, cfg_r.skip_empty_rows};
      default:                     prdata = 32'd0;
    endcase
  end

  // Hold intake while every free bank is spoken for.
  assign full = (({1'b0, q_count} + (CW + 1)'(back_busy)) >=
                 (CW + 1)'(csvt_pkg::NBANK - 1));

  csvt_ram #(
    .WIDTH(8),
    .DEPTH(csvt_pkg::NBANK << $clog2(CELL_MAX))
  ) u_ram (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .re(ram_re), .raddr(ram_raddr), .rdata(ram_rdata)
  );

  csvt_front #(.CELL_MAX(CELL_MAX), .COUNT_BITS(COUNT_BITS)) u_front (
    .clk(clk), .rst_n(rst_n), .cfg(cfg_r), .push(push), .full(full),
    .text_byte(in_text_byte), .end_of_text(in_end_of_text),
    .ram_we(ram_we), .ram_waddr(ram_waddr), .ram_wdata(ram_wdata),
    .job_push(job_push), .job(job_in)
  );

  csvt_jobq #(.DEPTH(csvt_pkg::JQ_DEPTH)) u_jobq (
    .clk(clk), .rst_n(rst_n), .push(job_push), .din(job_in), .pop(q_pop),
    .valid(q_valid), .dout(job_out), .count(q_count)
  );

  csvt_back #(.CELL_MAX(CELL_MAX)) u_back (
    .clk(clk), .rst_n(rst_n), .cfg(cfg_r), .q_valid(q_valid), .q_job(job_out),
    .q_pop(q_pop), .rd_en(ram_re), .rd_addr(ram_raddr), .rd_data(ram_rdata),
    .busy(back_busy), .pop(pop), .out_valid(out_valid), .out_res(res)
  );

  assign empty             = !out_valid;
  assign out_byte          = res.data;
  assign out_byte_valid    = res.byte_valid;
  assign out_cell_end      = res.cell_end;
  assign out_row_end       = res.row_end;
  assign out_cell_overflow = res.overflow;
  assign out_stream_end    = res.stream_end;
  assign out_crlf_style    = res.crlf;
  assign out_last          = res.last;

  `CSVT_ASSERT_IMP(a_bank_disjoint, clk, rst_n, ram_we && ram_re,
    ram_waddr[AW-1 -: csvt_pkg::BANK_W] != ram_raddr[AW-1 -: csvt_pkg::BANK_W])
  `CSVT_ASSERT_IMP(a_jobq_room, clk, rst_n, job_push,
    (q_count < CW'(csvt_pkg::JQ_DEPTH)) || q_pop)
  `CSVT_ASSERT_IMP(a_row_has_cell, clk, rst_n, !empty && out_row_end,
    out_cell_end && out_last)
  `CSVT_ASSERT_NXT(a_pop_needs_job, clk, rst_n, q_pop, back_busy)

endmodule
`default_nettype wire

// ===== tb/csv_tokenizer_checker.sv =====
`timescale 1ns / 1ps
module csv_tokenizer_checker
  import csvt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  logic        full,
  input  logic [7:0]  in_text_byte,
  input  logic        in_end_of_text,
  input  logic        empty,
  input  logic        pop,
  input  logic [7:0]  out_byte,
  input  logic        out_byte_valid,
  input  logic        out_cell_end,
  input  logic        out_row_end,
  input  logic        out_cell_overflow,
  input  logic        out_stream_end,
  input  logic        out_crlf_style,
  input  logic        out_last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          fail_count,
  output int          pending
);

  cfg_t        cfg;
  logic [7:0]  cell_bytes [64];
  int          cell_len;
  bit          started, first_quote, dropped, in_quotes, row_cells, row_comment;
  logic [31:0] cr_total, lf_total;
  res_t        cell_results_q [$];

  function automatic bit is_space(logic [7:0] b);
    return b == 8'd32 || (b >= 8'd9 && b <= 8'd13);
  endfunction

  task automatic report(string field, int want, int got);
    $display("[%0t] mismatch on %s: expected %0h, got %0h", $time, field, want, got);
    fail_count++;
  endtask

  task automatic clear_cell();
    cell_len = 0;
    started = 0;
    first_quote = 0;
    dropped = 0;
  endtask

  task automatic end_row();
    row_cells = 0;
    row_comment = 0;
    in_quotes = 0;
  endtask

  task automatic add_byte(logic [7:0] b);
    if (!started) first_quote = (b == QUOTE_CHAR);
    started = 1;
    if (cell_len < 64) begin
      cell_bytes[cell_len] = b;
      cell_len++;
    end else begin
      dropped = 1;
    end
  endtask

  // Trim, unquote and queue the bytes of the open cell.
  task automatic emit_cell(bit ends_row, output int k);
    logic [7:0] txt [$];
    int   lo, hi, i;
    bit   first;
    res_t r;
    lo = 0;
    hi = cell_len;
    first = !row_cells;
    if (cfg.trim_enable) begin
      while (lo < hi && is_space(cell_bytes[lo])) lo++;
      while (hi > lo && is_space(cell_bytes[hi-1])) hi--;
    end
    if (cfg.unquote_enable && hi - lo >= 2 && cell_bytes[lo] == QUOTE_CHAR &&
        cell_bytes[hi-1] == QUOTE_CHAR) begin
      i = lo + 1;
      while (i < hi - 1) begin
        txt = {txt, cell_bytes[i]};
        if (cell_bytes[i] == QUOTE_CHAR && i + 1 < hi - 1 && cell_bytes[i+1] == QUOTE_CHAR)
          i += 2;
        else
          i += 1;
      end
    end else begin
      for (i = lo; i < hi; i++) txt = {txt, cell_bytes[i]};
    end
    row_cells = 1;
    if (first)
      row_comment = cfg.skip_comment_rows && txt.size() > 0 && txt[0] == cfg.comment_char;
    k = 0;
    if (!row_comment) begin
      k = (txt.size() == 0) ? 1 : txt.size();
      for (i = 0; i < k; i++) begin
        r = '0;
        r.data       = (txt.size() == 0) ? 8'd0 : txt[i];
        r.byte_valid = (txt.size() != 0);
        r.cell_end   = (i == k - 1);
        r.row_end    = ends_row && (i == k - 1);
        r.overflow   = dropped;
        cell_results_q = {cell_results_q, r};
      end
    end
    clear_cell();
  endtask

  task automatic predict(logic [7:0] b, bit eot);
    int   k;
    res_t r;
    k = 0;
    if (eot) begin
      if (started || row_cells) emit_cell(1'b1, k);
      if (k == 0) begin
        r = '0;
        cell_results_q = {cell_results_q, r};
        k = 1;
      end
      cell_results_q[cell_results_q.size()-1].stream_end = 1'b1;
      cell_results_q[cell_results_q.size()-1].crlf = (cr_total > (lf_total >> 1));
      clear_cell();
      end_row();
      cr_total = '0;
      lf_total = '0;
    end else if (b == QUOTE_CHAR) begin
      if (!started || first_quote) in_quotes = !in_quotes;
      add_byte(b);
    end else if (b == cfg.separator_char) begin
      if (!in_quotes) emit_cell(1'b0, k);
      else add_byte(b);
    end else if (b == CR_CHAR) begin
      if (cfg.quoted_breaks_enable && in_quotes) add_byte(b);
      else cr_total++;
    end else if (b == LF_CHAR) begin
      if (cfg.quoted_breaks_enable && in_quotes) begin
        add_byte(b);
      end else begin
        lf_total++;
        // Blank line under skip: nothing, quoted state kept.
        if (!(cfg.skip_empty_rows && !row_cells && !started)) begin
          emit_cell(1'b1, k);
          end_row();
        end
      end
    end else begin
      add_byte(b);
    end
    if (k > 0) cell_results_q[cell_results_q.size()-1].last = 1'b1;
  endtask

  always @(posedge clk) begin
    res_t want;
    if (!rst_n) begin
      cfg <= '{separator_char: 8'd44, trim_enable: 1'b0, quoted_breaks_enable: 1'b0,
               unquote_enable: 1'b1, skip_comment_rows: 1'b0, comment_char: 8'd35,
               skip_empty_rows: 1'b0};
      clear_cell();
      end_row();
      cr_total = '0;
      lf_total = '0;
      cell_results_q.delete();
      fail_count <= 0;
      pending <= 0;
    end else begin
      if (pop && !empty) begin
        if (cell_results_q.size() == 0) begin
          report("unexpected transaction", 0, out_byte);
        end else begin
          want = cell_results_q.pop_front();
          if (out_byte !== want.data) report("out_byte", want.data, out_byte);
          if (out_byte_valid !== want.byte_valid)
            report("byte_valid", want.byte_valid, out_byte_valid);
          if (out_cell_end !== want.cell_end) report("cell_end", want.cell_end, out_cell_end);
          if (out_row_end !== want.row_end) report("row_end", want.row_end, out_row_end);
          if (out_cell_overflow !== want.overflow)
            report("cell_overflow", want.overflow, out_cell_overflow);
          if (out_stream_end !== want.stream_end)
            report("stream_end", want.stream_end, out_stream_end);
          if (out_crlf_style !== want.crlf) report("crlf_style", want.crlf, out_crlf_style);
          if (out_last !== want.last) report("last", want.last, out_last);
        end
      end
      if (push && !full) predict(in_text_byte, in_end_of_text);
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          REG_SEPARATOR:     cfg.separator_char <= pwdata[7:0];
          REG_TRIM:          cfg.trim_enable <= pwdata[0];
          REG_QUOTED_BREAKS: cfg.quoted_breaks_enable <= pwdata[0];
          REG_UNQUOTE:       cfg.unquote_enable <= pwdata[0];
          REG_SKIP_COMMENT:  cfg.skip_comment_rows <= pwdata[0];
          REG_COMMENT_CHAR:  cfg.comment_char <= pwdata[7:0];
          REG_SKIP_EMPTY:    cfg.skip_empty_rows <= pwdata[0];
          default: ;
        endcase
      end
      pending <= cell_results_q.size();
    end
  end

endmodule

// ===== tb/tb_csv_byte_tokenizer_core.sv =====
`timescale 1ns / 1ps
module tb_csv_byte_tokenizer_core;
  import csvt_pkg::*;

  localparam int IDLE_LIMIT = 20000;
  localparam int DRAIN_WAIT = 100;
  localparam int PHASE_ITEMS = 70;

  logic        clk, rst_n;
  logic        push, full, empty, pop;
  logic [7:0]  in_text_byte;
  logic        in_end_of_text;
  logic [7:0]  out_byte;
  logic        out_byte_valid, out_cell_end, out_row_end, out_cell_overflow;
  logic        out_stream_end, out_crlf_style, out_last;
  logic        psel, penable, pwrite, pready;
  logic [4:0]  paddr;
  logic [31:0] pwdata, prdata;
  int          fail_count, pending;
  int          burst_left, idle_cycles, cycle_n, sent_items;
  logic [7:0]  cur_sep, cur_comment;

  csv_byte_tokenizer_core u_dut (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full),
    .in_text_byte(in_text_byte), .in_end_of_text(in_end_of_text),
    .empty(empty), .pop(pop), .out_byte(out_byte), .out_byte_valid(out_byte_valid),
    .out_cell_end(out_cell_end), .out_row_end(out_row_end),
    .out_cell_overflow(out_cell_overflow), .out_stream_end(out_stream_end),
    .out_crlf_style(out_crlf_style), .out_last(out_last),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  csv_tokenizer_checker u_checker (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full),
    .in_text_byte(in_text_byte), .in_end_of_text(in_end_of_text),
    .empty(empty), .pop(pop), .out_byte(out_byte), .out_byte_valid(out_byte_valid),
    .out_cell_end(out_cell_end), .out_row_end(out_row_end),
    .out_cell_overflow(out_cell_overflow), .out_stream_end(out_stream_end),
    .out_crlf_style(out_crlf_style), .out_last(out_last),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready), .fail_count(fail_count), .pending(pending)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Receiver stall pattern: full rate, mostly on, mostly off, square wave.
  always @(posedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
      cycle_n <= 0;
    end else begin
      cycle_n <= cycle_n + 1;
      case ((cycle_n / 300) % 4)
        0: pop <= 1'b1;
        1: pop <= ($urandom_range(0, 99) < 70);
        2: pop <= ($urandom_range(0, 99) < 10);
        default: pop <= cycle_n[2];
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else if ((push && !full) || (pop && !empty)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_item(logic [7:0] b, bit eot);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    sent_items++;
    push <= 1'b1;
    in_text_byte <= b;
    in_end_of_text <= eot;
    do @(posedge clk); while (full);
  endtask

  task automatic send_text(string s);
    foreach (s[i]) send_item(s[i], 1'b0);
  endtask

  // Hold off until every result has drained, then let in-flight bytes settle.
  task automatic drain();
    push <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // Setup then access; the caller releases the bus after the last write.
  task automatic reg_write(logic [2:0] idx, logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
  endtask

  task automatic set_config(logic [7:0] sep, bit trim, bit qbreak, bit unq, bit skipc,
                            logic [7:0] cmt, bit skipe);
    reg_write(REG_SEPARATOR, sep);
    reg_write(REG_TRIM, trim);
    reg_write(REG_QUOTED_BREAKS, qbreak);
    reg_write(REG_UNQUOTE, unq);
    reg_write(REG_SKIP_COMMENT, skipc);
    reg_write(REG_COMMENT_CHAR, cmt);
    reg_write(REG_SKIP_EMPTY, skipe);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    cur_sep = sep;
    cur_comment = cmt;
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 9))
      0: return QUOTE_CHAR;
      1: return cur_sep;
      2: return ($urandom_range(0, 1) != 0) ? 8'd32 : 8'd9;
      3: return cur_comment;
      4: return 8'($urandom_range(0, 255));
      default: return 8'($urandom_range(97, 122));
    endcase
  endfunction

  task automatic send_cell();
    int n;
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        n = $urandom_range(0, 6);
        repeat (n) send_item(8'($urandom_range(48, 122)), 1'b0);
      end
      3, 4, 5: begin
        // Quoted cell with doubled quotes, separators and breaks inside.
        send_item(QUOTE_CHAR, 1'b0);
        n = $urandom_range(0, 6);
        repeat (n) begin
          case ($urandom_range(0, 5))
            0: begin
              send_item(QUOTE_CHAR, 1'b0);
              send_item(QUOTE_CHAR, 1'b0);
            end
            1: send_item(cur_sep, 1'b0);
            2: send_item(($urandom_range(0, 1) != 0) ? CR_CHAR : LF_CHAR, 1'b0);
            default: send_item(8'($urandom_range(97, 122)), 1'b0);
          endcase
        end
        if ($urandom_range(0, 7) != 0) send_item(QUOTE_CHAR, 1'b0);
      end
      6: begin
        send_item(8'd32, 1'b0);
        send_item(8'($urandom_range(97, 122)), 1'b0);
        send_item(8'd13 - 8'($urandom_range(0, 4)), 1'b0);
      end
      7: if ($urandom_range(0, 3) == 0) begin
        n = $urandom_range(60, 70);
        repeat (n) send_item(pick_byte(), 1'b0);
      end
      default: begin
        n = $urandom_range(1, 5);
        repeat (n) send_item(pick_byte(), 1'b0);
      end
    endcase
  endtask

  task automatic send_row();
    int cells;
    if ($urandom_range(0, 7) == 0) send_item(cur_comment, 1'b0);
    if ($urandom_range(0, 9) != 0) begin
      cells = $urandom_range(1, 4);
      for (int c = 0; c < cells; c++) begin
        send_cell();
        if (c < cells - 1) send_item(cur_sep, 1'b0);
      end
    end
    if ($urandom_range(0, 2) == 0) send_item(CR_CHAR, 1'b0);
    send_item(LF_CHAR, 1'b0);
  endtask

  task automatic random_phase();
    int first_item;
    first_item = sent_items;
    while (sent_items - first_item < PHASE_ITEMS) begin
      case ($urandom_range(0, 9))
        0: send_item(8'($urandom_range(0, 255)), 1'b0);
        1: send_item(8'($urandom_range(0, 255)), 1'b1);
        2: send_cell();
        default: send_row();
      endcase
    end
    send_item(8'($urandom_range(0, 255)), 1'b1);
  endtask

  initial begin
    rst_n = 1'b0;
    push = 1'b0;
    in_text_byte = '0;
    in_end_of_text = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    burst_left = 0;
    sent_items = 0;
    cur_sep = 8'd44;
    cur_comment = 8'd35;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: doubled quotes, empty cell, CRLF, extreme bytes, bare end.
    send_text("\"a\"\"b\",, x\r\n\"\"");
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(LF_CHAR, 1'b0);
    send_item(LF_CHAR, 1'b0);
    send_item(8'h5A, 1'b1);
    send_item(8'hA5, 1'b1);
    drain();
    set_config(8'd44, 1'b1, 1'b1, 1'b0, 1'b1, 8'd35, 1'b1);
    send_text("# c,d\n\n a ,\"x\ny\"");
    send_item(8'h00, 1'b1);
    drain();

    random_phase();
    drain();
    set_config(8'd0, 1'b1, 1'b1, 1'b1, 1'b1, 8'd0, 1'b1);
    random_phase();
    drain();
    set_config(8'd255, 1'b0, 1'b0, 1'b1, 1'b1, 8'd255, 1'b0);
    random_phase();
    drain();
    set_config(QUOTE_CHAR, 1'b1, 1'b0, 1'b1, 1'b0, 8'd35, 1'b1);
    random_phase();
    drain();
    set_config(LF_CHAR, 1'b0, 1'b1, 1'b0, 1'b1, 8'd97, 1'b0);
    random_phase();
    drain();
    set_config(8'd59, 1'b1, 1'b1, 1'b1, 1'b1, QUOTE_CHAR, 1'b1);
    random_phase();
    drain();

    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
